@@ rtl/dplru_pkg.sv @@
// Shared widths, codes and controller/datapath handshake types for the LRU replacement block.
package dplru_pkg;

    // Default geometry, handed to the top level parameters
    localparam int NUM_WAYS_DFLT = 16;
    localparam int NUM_SETS_DFLT = 2048;

    // Fixed field widths of the request and result items
    localparam int CMD_W   = 1;
    localparam int SET_W   = 11;
    localparam int WAY_W   = 4;
    localparam int MASK_W  = 16;
    localparam int MASK_IW = 4;
    localparam int THR_W   = 4;
    localparam int KIND_W  = 2;

    // Request commands
    localparam logic [CMD_W-1:0] CMD_FIND   = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b1;

    // Victim kinds
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LRU     = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic search;
        logic apply;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic result_due;
        logic out_busy;
    } t_dp_stat;

endpackage

@@ rtl/dplru_in_if.sv @@
// Request channel: valid/ready handshake with the find/update request payload.
interface dplru_in_if;
    logic                          valid;
    logic                          ready;
    logic [dplru_pkg::CMD_W-1:0]   command;
    logic [dplru_pkg::SET_W-1:0]   set_index;
    logic [dplru_pkg::WAY_W-1:0]   way;
    logic [dplru_pkg::MASK_W-1:0]  valid_mask;
    logic [dplru_pkg::MASK_W-1:0]  instr_mask;
    logic                          hit;
    logic                          is_writeback;

    modport source (
        output valid, command, set_index, way, valid_mask, instr_mask, hit, is_writeback,
        input  ready
    );

    modport sink (
        input  valid, command, set_index, way, valid_mask, instr_mask, hit, is_writeback,
        output ready
    );
endinterface

@@ rtl/dplru_out_if.sv @@
// Result channel: valid/ready handshake with the chosen victim way and its kind.
interface dplru_out_if;
    logic                          valid;
    logic                          ready;
    logic [dplru_pkg::WAY_W-1:0]   victim_way;
    logic [dplru_pkg::KIND_W-1:0]  victim_kind;

    modport source (
        output valid, victim_way, victim_kind,
        input  ready
    );

    modport sink (
        input  valid, victim_way, victim_kind,
        output ready
    );
endinterface

@@ rtl/dplru_ctrl.sv @@
// Controller state machine: clearing pass, request capture, search and write-back sequencing.
module dplru_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dplru_pkg::t_dp_stat i_stat,
    output dplru_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.search = 1'b1;
                n_state      = S_APPLY;
            end
            S_APPLY: begin
                // hold while a result is due and the output register cannot take it
                if (!(i_stat.result_due && i_stat.out_busy)) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // A transfer on the request channel always starts the row read
    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_READ))
        else $error("request transfer not followed by row read");

    // Search is always followed directly by the apply state
    a_read_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_APPLY))
        else $error("search not followed by apply");

    // Never overwrite a result the consumer has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |-> !(i_stat.result_due && i_stat.out_busy))
        else $error("apply issued while output register busy");

endmodule

@@ rtl/dplru_dp.sv @@
// Datapath: rank memory, victim search tree, rank update and output register.
module dplru_dp #(
    parameter int NUM_WAYS = dplru_pkg::NUM_WAYS_DFLT,
    parameter int NUM_SETS = dplru_pkg::NUM_SETS_DFLT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dplru_pkg::t_dp_cmd              i_cmd,
    output dplru_pkg::t_dp_stat             o_stat,
    input  logic                            i_cfg_wr_en,
    input  logic [dplru_pkg::THR_W-1:0]     i_cfg_wr_data,
    input  logic [dplru_pkg::CMD_W-1:0]     i_command,
    input  logic [dplru_pkg::SET_W-1:0]     i_set_index,
    input  logic [dplru_pkg::WAY_W-1:0]     i_way,
    input  logic [dplru_pkg::MASK_W-1:0]    i_valid_mask,
    input  logic [dplru_pkg::MASK_W-1:0]    i_instr_mask,
    input  logic                            i_hit,
    input  logic                            i_is_writeback,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [dplru_pkg::WAY_W-1:0]     o_victim_way,
    output logic [dplru_pkg::KIND_W-1:0]    o_victim_kind
);

    localparam int RW    = $clog2(NUM_WAYS);
    localparam int ROW_W = NUM_WAYS * RW;
    localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int CMPW  = ((SW > dplru_pkg::SET_W) ? SW : dplru_pkg::SET_W) + 1;
    localparam int SUMW  = ((RW > dplru_pkg::THR_W) ? RW : dplru_pkg::THR_W) + 1;
    localparam int P     = 2 ** RW;
    localparam logic [RW-1:0] RANK_OLDEST = RW'(NUM_WAYS - 1);

    typedef struct packed {
        logic          inv_f;
        logic [RW-1:0] inv_i;
        logic          pref_f;
        logic [RW-1:0] pref_r;
        logic [RW-1:0] pref_i;
        logic          plain_f;
        logic [RW-1:0] plain_i;
    } t_node;

    // Rank memory, one row of NUM_WAYS ranks per set
    logic [ROW_W-1:0] r_rank_mem [NUM_SETS];
    logic [ROW_W-1:0] r_rd_row;

    // Captured request
    logic                   r_cmd_upd;
    logic                   r_set_ok;
    logic [SW-1:0]          r_set_addr;
    logic                   r_way_ok;
    logic [RW-1:0]          r_way_idx;
    logic [dplru_pkg::MASK_W-1:0] r_vmask;
    logic [dplru_pkg::MASK_W-1:0] r_imask;
    logic                   r_skip;

    // Search results
    logic          r_inv_f;
    logic [RW-1:0] r_inv_i;
    logic          r_pref_f;
    logic [RW-1:0] r_pref_r;
    logic [RW-1:0] r_pref_i;
    logic [RW-1:0] r_plain_i;
    logic [RW-1:0] r_old;

    logic [dplru_pkg::THR_W-1:0] r_threshold;
    logic [SW-1:0]               r_clr_addr;
    logic [dplru_pkg::WAY_W-1:0] r_out_way;
    logic [dplru_pkg::KIND_W-1:0] r_out_kind;
    logic                        r_out_valid;

    logic [RW-1:0]    rank [P];
    t_node            nodes [1:2*P-1];
    logic [ROW_W-1:0] id_row;
    logic [ROW_W-1:0] n_row;
    logic             write_ok;
    logic             mem_we;
    logic [SW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_row;
    logic             result_due;
    logic [dplru_pkg::WAY_W-1:0]  n_out_way;
    logic [dplru_pkg::KIND_W-1:0] n_out_kind;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_wr_en) begin
            r_threshold <= i_cfg_wr_data;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_upd  <= (i_command == dplru_pkg::CMD_UPDATE);
            r_set_ok   <= (CMPW'(i_set_index) < CMPW'(NUM_SETS));
            r_set_addr <= SW'(i_set_index);
            r_way_ok   <= (SUMW'(i_way) < SUMW'(NUM_WAYS));
            r_way_idx  <= RW'(i_way);
            r_vmask    <= i_valid_mask;
            r_imask    <= i_instr_mask;
            r_skip     <= i_hit && i_is_writeback;
        end
    end

    // Read the set's rank row on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd_row <= r_rank_mem[SW'(i_set_index)];
        end
    end

    // Unpack ranks; pad unused leaves with zero
    always_comb begin
        for (int w = 0; w < P; w++) begin
            rank[w] = '0;
            if (w < NUM_WAYS) begin
                rank[w] = r_rd_row[w*RW +: RW];
            end
        end
    end

    // Victim search: leaves, then a tree merging toward the lowest node
    always_comb begin
        logic vbit;
        logic ibit;
        logic qual;
        t_node l;
        t_node r;
        for (int w = 0; w < P; w++) begin
            nodes[P+w] = '0;
            if (w < NUM_WAYS) begin
                // ways beyond the mask width count as valid data ways
                vbit = (w < dplru_pkg::MASK_W) ? r_vmask[w[dplru_pkg::MASK_IW-1:0]] : 1'b1;
                ibit = (w < dplru_pkg::MASK_W) ? r_imask[w[dplru_pkg::MASK_IW-1:0]] : 1'b0;
                qual = (SUMW'(rank[w]) + SUMW'(r_threshold)) >= SUMW'(NUM_WAYS);
                nodes[P+w].inv_f   = !vbit;
                nodes[P+w].inv_i   = RW'(w);
                nodes[P+w].pref_f  = !ibit && (rank[w] != '0) && qual;
                nodes[P+w].pref_r  = rank[w];
                nodes[P+w].pref_i  = RW'(w);
                nodes[P+w].plain_f = (rank[w] == RANK_OLDEST);
                nodes[P+w].plain_i = RW'(w);
            end
        end
        for (int k = P - 1; k >= 1; k--) begin
            l = nodes[2*k];
            r = nodes[2*k+1];
            nodes[k] = l;
            // lowest invalid way
            if (!l.inv_f) begin
                nodes[k].inv_f = r.inv_f;
                nodes[k].inv_i = r.inv_i;
            end
            // oldest qualifying data way, lower way on equal ranks
            if (r.pref_f && (!l.pref_f || (r.pref_r > l.pref_r))) begin
                nodes[k].pref_f = r.pref_f;
                nodes[k].pref_r = r.pref_r;
                nodes[k].pref_i = r.pref_i;
            end
            // highest way holding the oldest rank
            if (r.plain_f) begin
                nodes[k].plain_f = r.plain_f;
                nodes[k].plain_i = r.plain_i;
            end
        end
    end

    // Register search results and the touched way's old rank
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_inv_f   <= nodes[1].inv_f;
            r_inv_i   <= nodes[1].inv_i;
            r_pref_f  <= nodes[1].pref_f;
            r_pref_r  <= nodes[1].pref_r;
            r_pref_i  <= nodes[1].pref_i;
            r_plain_i <= nodes[1].plain_i;
            r_old     <= rank[r_way_idx];
        end
    end

    // Build the updated row
    always_comb begin
        n_row = r_rd_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (r_cmd_upd) begin
                if (RW'(w) == r_way_idx) begin
                    n_row[w*RW +: RW] = '0;
                end else if (rank[w] <= r_old) begin
                    n_row[w*RW +: RW] = rank[w] + RW'(1);
                end
            end else begin
                if (RW'(w) == r_pref_i) begin
                    n_row[w*RW +: RW] = RANK_OLDEST;
                end else if (rank[w] > r_pref_r) begin
                    n_row[w*RW +: RW] = rank[w] - RW'(1);
                end
            end
        end
    end

    assign write_ok = r_set_ok && (r_cmd_upd ? (r_way_ok && !r_skip)
                                             : (!r_inv_f && r_pref_f));

    // Identity row for the clearing pass
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            id_row[w*RW +: RW] = RW'(w);
        end
    end

    assign mem_we  = i_cmd.clear_step || (i_cmd.apply && write_ok);
    assign wr_addr = i_cmd.clear_step ? r_clr_addr : r_set_addr;
    assign wr_row  = i_cmd.clear_step ? id_row : n_row;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rank_mem[wr_addr] <= wr_row;
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + SW'(1);
        end
    end

    // Result selection
    assign result_due = !r_cmd_upd && r_set_ok;
    always_comb begin
        if (r_inv_f) begin
            n_out_way  = dplru_pkg::WAY_W'(r_inv_i);
            n_out_kind = dplru_pkg::KIND_INVALID;
        end else if (r_pref_f) begin
            n_out_way  = dplru_pkg::WAY_W'(r_pref_i);
            n_out_kind = dplru_pkg::KIND_DATA;
        end else begin
            n_out_way  = dplru_pkg::WAY_W'(r_plain_i);
            n_out_kind = dplru_pkg::KIND_LRU;
        end
    end

    // Output register: load on apply, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply && result_due) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && result_due) begin
            r_out_way  <= n_out_way;
            r_out_kind <= n_out_kind;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_victim_way  = r_out_way;
    assign o_victim_kind = r_out_kind;

    assign o_stat.clear_last = (r_clr_addr == SW'(NUM_SETS - 1));
    assign o_stat.result_due = result_due;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    // An in-range find that completes always presents its result next cycle
    a_find_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && result_due) |=> r_out_valid)
        else $error("find completed without a result");

endmodule

@@ rtl/data_preferring_lru_replacement.sv @@
// Top level of the data-preferring true-LRU replacement block.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        command, set_index, way, valid_mask, instr_mask,
//                                    hit, is_writeback
//  o_out     out  valid/ready        victim_way, victim_kind (one per in-range find)
//  i_cfg     in   i_cfg_wr_en        i_cfg_wr_data = data-victim rank threshold
//
//  Each request goes through transfer and rank row read, search, then rank
//  write-back and result load; this rank memory read-modify-write ends before the next request is taken.
//  After reset a clearing pass writes every set's rank row (NUM_SETS rows, 2048 by
//  default) with i_in.ready low; configuration writes are taken meanwhile.
//  Results sit in an output register; the next request is taken while one waits, and
//  an in-range find stalls before its write-back only while the previous result is still untaken.
module data_preferring_lru_replacement #(
    parameter int NUM_WAYS = dplru_pkg::NUM_WAYS_DFLT,
    parameter int NUM_SETS = dplru_pkg::NUM_SETS_DFLT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [dplru_pkg::THR_W-1:0] i_cfg_wr_data,
    dplru_in_if.sink                    i_in,
    dplru_out_if.source                 o_out
);

    dplru_pkg::t_dp_cmd  cmd;
    dplru_pkg::t_dp_stat stat;

    // Sequencer
    dplru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Rank storage and victim logic
    dplru_dp #(
        .NUM_WAYS (NUM_WAYS),
        .NUM_SETS (NUM_SETS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (i_in.command),
        .i_set_index    (i_in.set_index),
        .i_way          (i_in.way),
        .i_valid_mask   (i_in.valid_mask),
        .i_instr_mask   (i_in.instr_mask),
        .i_hit          (i_in.hit),
        .i_is_writeback (i_in.is_writeback),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_victim_way   (o_out.victim_way),
        .o_victim_kind  (o_out.victim_kind)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the data-preferring true-LRU replacement block.
module testbench;

    localparam int N_WAYS        = dplru_pkg::NUM_WAYS_DFLT;
    localparam int N_SETS        = dplru_pkg::NUM_SETS_DFLT;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 80;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [dplru_pkg::CMD_W-1:0]  command;
        logic [dplru_pkg::SET_W-1:0]  set_index;
        logic [dplru_pkg::WAY_W-1:0]  way;
        logic [dplru_pkg::MASK_W-1:0] valid_mask;
        logic [dplru_pkg::MASK_W-1:0] instr_mask;
        logic                         hit;
        logic                         is_writeback;
    } t_req;

    typedef struct packed {
        logic [dplru_pkg::WAY_W-1:0]  way;
        logic [dplru_pkg::KIND_W-1:0] kind;
    } t_victim;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [dplru_pkg::THR_W-1:0] i_cfg_wr_data = '0;

    dplru_in_if  req_ch ();
    dplru_out_if res_ch ();

    data_preferring_lru_replacement i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (req_ch),
        .o_out         (res_ch)
    );

    // Shadow copy of the rank rows and the threshold register
    logic [dplru_pkg::WAY_W-1:0] rank_tbl [0:N_SETS-1][0:N_WAYS-1];
    logic [dplru_pkg::THR_W-1:0] thr_q;

    t_req    pending_reqs [$];
    t_victim victims_due [$];
    logic [dplru_pkg::SET_W-1:0] hot_sets [0:7];

    int  n_queued;
    int  n_accepted;
    int  n_finds;
    int  n_checked;
    int  errors;
    int  cycle_cnt;
    bit  no_idle;
    bit  long_hold_go;
    bit  long_hold_done;

    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow ranks; return 1 when it yields a victim
    function automatic bit predict_victim(input t_req r, output t_victim v);
        int old_rank;
        int need;
        int best;
        int pref;
        int plain;
        int rk;
        v = '0;
        if (r.command == dplru_pkg::CMD_UPDATE) begin
            if (r.hit && r.is_writeback)
                return 1'b0;
            old_rank = rank_tbl[r.set_index][r.way];
            for (int w = 0; w < N_WAYS; w++)
                if (rank_tbl[r.set_index][w] <= old_rank)
                    rank_tbl[r.set_index][w] = rank_tbl[r.set_index][w] + 1'b1;
            rank_tbl[r.set_index][r.way] = '0;
            return 1'b0;
        end
        // Lowest invalid way wins outright
        for (int w = 0; w < N_WAYS; w++) begin
            if (!r.valid_mask[w]) begin
                v.way  = dplru_pkg::WAY_W'(w);
                v.kind = dplru_pkg::KIND_INVALID;
                return 1'b1;
            end
        end
        need  = (thr_q >= N_WAYS) ? 0 : N_WAYS - int'(thr_q);
        best  = 0;
        pref  = 0;
        plain = 0;
        for (int w = 0; w < N_WAYS; w++) begin
            rk = rank_tbl[r.set_index][w];
            if (!r.instr_mask[w] && rk > best && rk >= need) begin
                best = rk;
                pref = w;
            end
            if (rk == N_WAYS - 1)
                plain = w;
        end
        if (best != 0) begin
            for (int w = 0; w < N_WAYS; w++)
                if (rank_tbl[r.set_index][w] > best)
                    rank_tbl[r.set_index][w] = rank_tbl[r.set_index][w] - 1'b1;
            rank_tbl[r.set_index][pref] = dplru_pkg::WAY_W'(N_WAYS - 1);
            v.way  = dplru_pkg::WAY_W'(pref);
            v.kind = dplru_pkg::KIND_DATA;
        end else begin
            v.way  = dplru_pkg::WAY_W'(plain);
            v.kind = dplru_pkg::KIND_LRU;
        end
        return 1'b1;
    endfunction

    task automatic queue_request(input logic [dplru_pkg::CMD_W-1:0] cmd, input int set_idx,
                                 input int way, input int vmask, input int imask,
                                 input bit hit, input bit wb);
        t_req r;
        r.command      = cmd;
        r.set_index    = dplru_pkg::SET_W'(set_idx);
        r.way          = dplru_pkg::WAY_W'(way);
        r.valid_mask   = dplru_pkg::MASK_W'(vmask);
        r.instr_mask   = dplru_pkg::MASK_W'(imask);
        r.hit          = hit;
        r.is_writeback = wb;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // Random request, mostly on a few hot sets so rank rows age deeply
    function automatic t_req random_request();
        t_req r;
        int   sel;
        r.command   = ($urandom_range(0, 99) < 45) ? dplru_pkg::CMD_FIND
                                                   : dplru_pkg::CMD_UPDATE;
        r.set_index = ($urandom_range(0, 9) == 0)
                      ? dplru_pkg::SET_W'($urandom_range(0, N_SETS - 1))
                      : hot_sets[$urandom_range(0, 7)];
        r.way       = dplru_pkg::WAY_W'($urandom_range(0, N_WAYS - 1));
        sel = $urandom_range(0, 19);
        if (sel < 14)
            r.valid_mask = 16'hFFFF;
        else if (sel < 17)
            r.valid_mask = 16'hFFFF & ~(16'h1 << $urandom_range(0, 15));
        else if (sel < 19)
            r.valid_mask = dplru_pkg::MASK_W'($urandom_range(0, 16'hFFFF));
        else
            r.valid_mask = 16'h0000;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            r.instr_mask = 16'h0000;
        else if (sel == 1)
            r.instr_mask = 16'hFFFF;
        else
            r.instr_mask = dplru_pkg::MASK_W'($urandom_range(0, 16'hFFFF));
        r.hit          = 1'($urandom_range(0, 1));
        r.is_writeback = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Block until every request is taken and every victim has come back
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (n_accepted != n_queued || victims_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= dplru_pkg::THR_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        thr_q = dplru_pkg::THR_W'(value);
    endtask

    task automatic random_phase(input int value, input int count);
        write_threshold(value);
        for (int k = 0; k < count; k++) begin
            pending_reqs.push_back(random_request());
            n_queued++;
        end
        wait_idle();
    endtask

    // Request driver: hold the payload until the transfer, insert random gaps
    t_req    drive_req;
    t_victim drive_victim;
    int      gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                if (predict_victim(drive_req, drive_victim))
                    victims_due.push_back(drive_victim);
                if (drive_req.command == dplru_pkg::CMD_FIND)
                    n_finds++;
                n_accepted++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (!no_idle && gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    req_ch.valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 99) < 15) begin
                    gap_left = $urandom_range(1, 14) - 1;
                    req_ch.valid <= 1'b0;
                end else begin
                    drive_req = pending_reqs.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.command      <= drive_req.command;
                    req_ch.set_index    <= drive_req.set_index;
                    req_ch.way          <= drive_req.way;
                    req_ch.valid_mask   <= drive_req.valid_mask;
                    req_ch.instr_mask   <= drive_req.instr_mask;
                    req_ch.hit          <= drive_req.hit;
                    req_ch.is_writeback <= drive_req.is_writeback;
                end
            end
        end
    end

    // Result monitor: check each transfer, stall ready in bursts and once for long
    t_victim got_victim;
    int      stall_left;
    int      hold_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            hold_cnt   = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (victims_due.size() == 0) begin
                    $display("%0t: victim with none pending: way %0d kind %0d",
                             $time, res_ch.victim_way, res_ch.victim_kind);
                    errors++;
                end else begin
                    got_victim = victims_due.pop_front();
                    if (res_ch.victim_way !== got_victim.way) begin
                        $display("%0t: victim_way mismatch: expected %0d, actual %0d",
                                 $time, got_victim.way, res_ch.victim_way);
                        errors++;
                    end
                    if (res_ch.victim_kind !== got_victim.kind) begin
                        $display("%0t: victim_kind mismatch: expected %0d, actual %0d",
                                 $time, got_victim.kind, res_ch.victim_kind);
                        errors++;
                    end
                    n_checked++;
                end
            end
            if (long_hold_go && !long_hold_done) begin
                if (hold_cnt < LONG_HOLD) begin
                    hold_cnt++;
                    res_ch.ready <= 1'b0;
                end else begin
                    long_hold_done = 1'b1;
                    res_ch.ready <= 1'b1;
                end
            end else if (!no_idle && stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 15) begin
                stall_left = $urandom_range(1, 14) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d victims outstanding",
                     $time, cycle_cnt, victims_due.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.command      = dplru_pkg::CMD_FIND;
        req_ch.set_index    = '0;
        req_ch.way          = '0;
        req_ch.valid_mask   = '0;
        req_ch.instr_mask   = '0;
        req_ch.hit          = 1'b0;
        req_ch.is_writeback = 1'b0;
        res_ch.ready        = 1'b0;
        thr_q = '0;
        for (int s = 0; s < N_SETS; s++)
            for (int w = 0; w < N_WAYS; w++)
                rank_tbl[s][w] = dplru_pkg::WAY_W'(w);
        hot_sets[0] = '0;
        hot_sets[1] = dplru_pkg::SET_W'(N_SETS - 1);
        for (int k = 2; k < 8; k++)
            hot_sets[k] = dplru_pkg::SET_W'($urandom_range(0, N_SETS - 1));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Threshold zero: no data way can qualify
        write_threshold(0);
        queue_request(dplru_pkg::CMD_FIND,   0,    0,  16'h0000, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   2047, 0,  16'h7FFF, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   0,    0,  16'hFFFF, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_UPDATE, 0,    3,  16'hFFFF, 16'hFFFF, 1, 1);
        queue_request(dplru_pkg::CMD_UPDATE, 0,    15, 16'h0000, 16'h0000, 0, 1);
        queue_request(dplru_pkg::CMD_UPDATE, 0,    0,  16'h0000, 16'h0000, 1, 0);
        queue_request(dplru_pkg::CMD_FIND,   0,    15, 16'hFFFF, 16'hFFFF, 1, 1);
        queue_request(dplru_pkg::CMD_FIND,   2047, 0,  16'hFFFE, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_UPDATE, 2047, 15, 16'hFFFF, 16'h0000, 1, 0);
        wait_idle();

        // Highest threshold: any aged data way qualifies
        write_threshold(15);
        queue_request(dplru_pkg::CMD_FIND,   0,    0,  16'hFFFF, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   0,    0,  16'hFFFF, 16'hFFFF, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   0,    0,  16'hFFFF, 16'h7FFF, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   2047, 0,  16'hFFFF, 16'hAAAA, 0, 0);
        queue_request(dplru_pkg::CMD_UPDATE, 5,    15, 16'h0000, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   5,    0,  16'hFFFF, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   1,    0,  16'h8000, 16'h0000, 0, 0);
        wait_idle();

        // Threshold one: only the oldest rank qualifies
        write_threshold(1);
        queue_request(dplru_pkg::CMD_FIND,   3,    0,  16'hFFFF, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   3,    0,  16'hFFFF, 16'h0000, 0, 0);
        queue_request(dplru_pkg::CMD_FIND,   3,    0,  16'hFFFF, 16'h8000, 0, 0);
        queue_request(dplru_pkg::CMD_UPDATE, 3,    15, 16'h0000, 16'h0000, 1, 0);
        queue_request(dplru_pkg::CMD_FIND,   3,    0,  16'hFFFF, 16'h0000, 0, 0);
        wait_idle();

        // Random traffic across several thresholds
        random_phase($urandom_range(2, 14), 85);
        random_phase(15, 85);
        random_phase(0, 80);
        long_hold_go = 1'b1;
        random_phase($urandom_range(2, 14), 85);
        random_phase(1, 80);
        no_idle = 1'b1;
        random_phase($urandom_range(0, 15), 85);

        if (victims_due.size() != 0) begin
            $display("%0t: %0d victims never arrived", $time, victims_due.size());
            errors++;
        end
        $display("summary: %0d requests taken, %0d of them finds, %0d victims checked",
                 n_accepted, n_finds, n_checked);
        $display("summary: thresholds 0, 1, 15 and random; long output stall; %0d errors",
                 errors);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

@@ data_preferring_lru_replacement.f @@
rtl/dplru_pkg.sv
rtl/dplru_in_if.sv
rtl/dplru_out_if.sv
rtl/dplru_ctrl.sv
rtl/dplru_dp.sv
rtl/data_preferring_lru_replacement.sv
sim/testbench.sv
